@@ src/wsc_pkg.sv @@
// Shared types, constants and the arctangent table of the waypoint steering controller.
// Used by the controller, the datapath and the top level.
package wsc_pkg;

	typedef enum logic [2:0] {
		CFG_STEER_GAIN   = 3'd0,
		CFG_STEER_CENTER = 3'd1,
		CFG_STEER_MIN    = 3'd2,
		CFG_STEER_MAX    = 3'd3,
		CFG_ARRIVE_RAD   = 3'd4,
		CFG_HEADING_TOL  = 3'd5,
		CFG_DRIVE_SPEED  = 3'd6,
		CFG_POWER_EN     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic write_wp;
		logic load_fix;
		logic cos_init;
		logic cos_step;
		logic mul;
		logic vec_init;
		logic vec_step;
		logic div_init;
		logic div_step;
		logic prod;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic route_end;
		logic cordic_last;
	} stat_t;

	localparam logic signed [33:0] K_Q30      = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
	localparam logic [30:0]        DEG90      = 31'd900000000;
	localparam logic [30:0]        DEG180     = 31'd1800000000;
	localparam logic signed [33:0] DEG180_T   = 34'sd1800000000;
	localparam logic signed [33:0] DEG360_T   = 34'sd3600000000;
	localparam logic [31:0]        HALF_UNIT  = 32'd50000;
	localparam logic [27:0]        RECIP_M    = 28'd175921861;
	localparam logic [15:0]        FULL_TURN  = 16'd36000;
	localparam logic [6:0]         DIST_SCALE = 7'd100;
	localparam logic [31:0]        NEAR_LIM   = 32'd1048576;

	function automatic logic [29:0] atan_at(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd450000000;
			5'd1:  v = 30'd265650512;
			5'd2:  v = 30'd140362435;
			5'd3:  v = 30'd71250163;
			5'd4:  v = 30'd35763344;
			5'd5:  v = 30'd17899106;
			5'd6:  v = 30'd8951737;
			5'd7:  v = 30'd4476142;
			5'd8:  v = 30'd2238105;
			5'd9:  v = 30'd1119057;
			5'd10: v = 30'd559529;
			5'd11: v = 30'd279765;
			5'd12: v = 30'd139882;
			5'd13: v = 30'd69941;
			5'd14: v = 30'd34971;
			5'd15: v = 30'd17485;
			5'd16: v = 30'd8743;
			5'd17: v = 30'd4371;
			5'd18: v = 30'd2186;
			5'd19: v = 30'd1093;
			5'd20: v = 30'd546;
			5'd21: v = 30'd273;
			5'd22: v = 30'd137;
			5'd23: v = 30'd68;
			5'd24: v = 30'd34;
			5'd25: v = 30'd17;
			5'd26: v = 30'd9;
			5'd27: v = 30'd4;
			5'd28: v = 30'd2;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ src/wsc_ctrl.sv @@
// Sequencing state machine of the waypoint steering controller.
// Depends on wsc_pkg; drives commands into wsc_dp and owns both handshakes.
module wsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            op,
	output logic            out_valid,
	input  logic            out_stall,
	input  wsc_pkg::stat_t  stat,
	output wsc_pkg::cmd_t   cmd
);
	import wsc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_READ  = 10'b0000000010,
		ST_COS   = 10'b0000000100,
		ST_MUL   = 10'b0000001000,
		ST_VINIT = 10'b0000010000,
		ST_VEC   = 10'b0000100000,
		ST_DINIT = 10'b0001000000,
		ST_DIV   = 10'b0010000000,
		ST_PROD  = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !op) begin
					cmd.write_wp = 1'b1;
				end else if (accept) begin
					cmd.load_fix = 1'b1;
					state_d = stat.route_end ? ST_FIN : ST_READ;
				end
			end
			ST_READ: begin
				cmd.cos_init = 1'b1;
				state_d = ST_COS;
			end
			ST_COS: begin
				cmd.cos_step = 1'b1;
				if (stat.cordic_last) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_VINIT;
			end
			ST_VINIT: begin
				cmd.vec_init = 1'b1;
				state_d = ST_VEC;
			end
			ST_VEC: begin
				cmd.vec_step = 1'b1;
				if (stat.cordic_last) state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/wsc_dp.sv @@
// Datapath of the waypoint steering controller: route memory, configuration,
// cosine and bearing CORDIC, bearing rounding divider and steering decision.
// Depends on wsc_pkg; sequenced by wsc_ctrl.
module wsc_dp #(
	parameter int ROUTE_DEPTH  = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wsc_pkg::cmd_t       cmd,
	output wsc_pkg::stat_t      stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [14:0]         cfg_data,
	input  logic [5:0]          slot,
	input  logic signed [30:0]  lat,
	input  logic signed [31:0]  lon,
	input  logic [15:0]         heading,
	input  logic signed [16:0]  turn_heading,
	output logic [14:0]         steer,
	output logic [7:0]          speed_cmd,
	output logic                power_cmd,
	output logic [15:0]         target_bearing,
	output logic [5:0]          active_index,
	output logic                in_radius,
	output logic                advanced,
	output logic                route_done
);
	import wsc_pkg::*;

	localparam int AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int LW = $clog2(ROUTE_DEPTH + 1);
	localparam int CW = $clog2(CORDIC_STEPS) + 1;

	logic signed [30:0] mem_lat [ROUTE_DEPTH];
	logic signed [31:0] mem_lon [ROUTE_DEPTH];
	logic signed [16:0] mem_turn [ROUTE_DEPTH];

	logic [4:0]  gain_q;
	logic [14:0] center_q, min_q, max_q, tol_q;
	logic [9:0]  radius_q;
	logic [7:0]  speed_q;
	logic        power_q;
	logic [LW-1:0] len_q, cur_q;

	logic signed [30:0] rd_lat_q, fix_lat_q;
	logic signed [31:0] rd_lon_q, fix_lon_q;
	logic signed [16:0] rd_turn_q;
	logic [15:0]        fix_head_q;
	logic               done_q;

	logic [CW-1:0]      ctr_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic               cneg_q;
	logic signed [63:0] vx_q, vy_q;
	logic signed [31:0] vz_q;
	logic               base_q, zero_q;
	logic [26:0]        rem_q;
	logic [15:0]        quo_q;

	logic signed [22:0] prod_q;
	logic [39:0]        sq_lat_q, sq_lon_q;
	logic [33:0]        rsq_q;
	logic               near_q;
	logic [15:0]        bearing_q;

	logic [14:0] steer_q;
	logic [7:0]  speed_out_q;
	logic        power_out_q;
	logic [15:0] bearing_out_q;
	logic [5:0]  index_q;
	logic        inside_out_q, adv_q, done_out_q;

	logic              slot_ok;
	logic [4:0]        sh;
	logic signed [31:0] atan_s;
	logic [30:0]       a_abs, a_fold;
	logic signed [33:0] xc;
	logic [28:0]       cmag;
	logic signed [29:0] cos_s;
	logic signed [31:0] dlat;
	logic signed [32:0] dlon;
	logic signed [62:0] prod_vy;
	logic signed [33:0] t_raw, t_wrap;
	logic [54:0]       recip_prod;
	logic [15:0]       h_c, bearing_c;
	logic signed [16:0] err;
	logic signed [22:0] prod_c;
	logic [31:0]       alat;
	logic [32:0]       alon;
	logic [16:0]       rad_c;
	logic              inside_c, match_c;
	logic signed [24:0] steer_raw, steer_cl;
	logic signed [17:0] hd;
	logic [17:0]       hd_abs;
	logic [LW-1:0]     cur_next;

	assign slot_ok = (32'(slot) < ROUTE_DEPTH);
	assign sh      = 5'(ctr_q);
	assign atan_s  = $signed({2'b00, atan_at(sh)});

	assign stat.route_end   = (cur_q >= len_q);
	assign stat.cordic_last = (ctr_q == CW'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.write_wp && slot_ok) begin
			mem_lat[AW'(slot)]  <= lat;
			mem_lon[AW'(slot)]  <= lon;
			mem_turn[AW'(slot)] <= turn_heading;
		end
		if (cmd.load_fix) begin
			rd_lat_q  <= mem_lat[cur_q[AW-1:0]];
			rd_lon_q  <= mem_lon[cur_q[AW-1:0]];
			rd_turn_q <= mem_turn[cur_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 5'd5;
			center_q <= 15'd9000;
			min_q    <= 15'd6000;
			max_q    <= 15'd12000;
			radius_q <= 10'd3;
			tol_q    <= 15'd500;
			speed_q  <= 8'd5;
			power_q  <= 1'b1;
			len_q    <= '0;
			cur_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_STEER_GAIN:   gain_q   <= cfg_data[4:0];
					CFG_STEER_CENTER: center_q <= cfg_data;
					CFG_STEER_MIN:    min_q    <= cfg_data;
					CFG_STEER_MAX:    max_q    <= cfg_data;
					CFG_ARRIVE_RAD:   radius_q <= cfg_data[9:0];
					CFG_HEADING_TOL:  tol_q    <= cfg_data;
					CFG_DRIVE_SPEED:  speed_q  <= cfg_data[7:0];
					CFG_POWER_EN:     power_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.write_wp && slot_ok) begin
				len_q <= LW'({1'b0, slot} + 7'd1);
			end
			if (cmd.fin && !done_q && inside_c && match_c) begin
				cur_q <= cur_next;
			end
		end
	end

	// Cosine of the waypoint latitude folded into the first quadrant.
	always_comb begin
		a_abs  = rd_lat_q[30] ? 31'(-rd_lat_q) : 31'(rd_lat_q);
		a_fold = (a_abs > DEG90) ? (DEG180 - a_abs) : a_abs;
		if (cx_q < 0) begin
			xc = '0;
		end else if (cx_q > ONE_Q30) begin
			xc = ONE_Q30;
		end else begin
			xc = cx_q;
		end
		cmag  = xc[30:2];
		cos_s = cneg_q ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
	end

	assign dlat    = 32'(rd_lat_q) - 32'(fix_lat_q);
	assign dlon    = 33'(rd_lon_q) - 33'(fix_lon_q);
	assign prod_vy = dlon * cos_s;

	always_comb begin
		t_raw = (base_q ? DEG180_T : 34'sd0) + 34'(vz_q);
		t_wrap = t_raw;
		if (t_wrap < 0) t_wrap = t_wrap + DEG360_T;
		if (t_wrap >= DEG360_T) t_wrap = t_wrap - DEG360_T;
	end

	// Division by 100000 as a division by 32 and a reciprocal multiply for 3125.
	assign recip_prod = rem_q * RECIP_M;

	always_comb begin
		h_c       = (quo_q >= FULL_TURN) ? 16'd0 : quo_q;
		bearing_c = zero_q ? 16'd0 : h_c;
		err       = $signed({1'b0, bearing_c}) - $signed({1'b0, fix_head_q});
		prod_c    = $signed({1'b0, gain_q}) * err;
		alat      = dlat[31] ? 32'(-dlat) : 32'(dlat);
		alon      = dlon[32] ? 33'(-dlon) : 33'(dlon);
		rad_c     = radius_q * DIST_SCALE;
	end

	always_comb begin
		inside_c  = near_q && ((41'(sq_lat_q) + 41'(sq_lon_q)) < 41'(rsq_q));
		hd        = $signed({2'b00, fix_head_q}) - 18'(rd_turn_q);
		hd_abs    = hd[17] ? 18'(-hd) : 18'(hd);
		match_c   = (hd_abs < 18'(tol_q));
		cur_next  = cur_q + 1'b1;
		steer_raw = $signed({10'd0, center_q}) - 25'(prod_q);
		steer_cl  = steer_raw;
		if (steer_cl < $signed({10'd0, min_q})) steer_cl = $signed({10'd0, min_q});
		if (steer_cl > $signed({10'd0, max_q})) steer_cl = $signed({10'd0, max_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fix) begin
			fix_lat_q  <= lat;
			fix_lon_q  <= lon;
			fix_head_q <= heading;
			done_q     <= stat.route_end;
		end
		if (cmd.cos_init) begin
			cx_q   <= K_Q30;
			cy_q   <= '0;
			cz_q   <= $signed({1'b0, a_fold});
			cneg_q <= (a_abs > DEG90);
			ctr_q  <= '0;
		end
		if (cmd.cos_step) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - (cy_q >>> sh);
				cy_q <= cy_q + (cx_q >>> sh);
				cz_q <= cz_q - atan_s;
			end else begin
				cx_q <= cx_q + (cy_q >>> sh);
				cy_q <= cy_q - (cx_q >>> sh);
				cz_q <= cz_q + atan_s;
			end
			ctr_q <= ctr_q + 1'b1;
		end
		if (cmd.mul) begin
			vy_q <= 64'(prod_vy);
			vx_q <= 64'($signed({dlat, 28'd0}));
		end
		if (cmd.vec_init) begin
			zero_q <= (vx_q == 0) && (vy_q == 0);
			base_q <= (vx_q < 0);
			if (vx_q < 0) begin
				vx_q <= -vx_q;
				vy_q <= -vy_q;
			end
			vz_q  <= '0;
			ctr_q <= '0;
		end
		if (cmd.vec_step) begin
			if (vy_q > 0) begin
				vx_q <= vx_q + (vy_q >>> sh);
				vy_q <= vy_q - (vx_q >>> sh);
				vz_q <= vz_q + atan_s;
			end else begin
				vx_q <= vx_q - (vy_q >>> sh);
				vy_q <= vy_q + (vx_q >>> sh);
				vz_q <= vz_q - atan_s;
			end
			ctr_q <= ctr_q + 1'b1;
		end
		if (cmd.div_init) begin
			rem_q <= 27'((32'(t_wrap) + HALF_UNIT) >> 5);
		end
		if (cmd.div_step) begin
			quo_q <= recip_prod[54:39];
		end
		if (cmd.prod) begin
			bearing_q <= bearing_c;
			prod_q    <= prod_c;
			near_q    <= (alat < NEAR_LIM) && (alon < 33'(NEAR_LIM));
			sq_lat_q  <= alat[19:0] * alat[19:0];
			sq_lon_q  <= alon[19:0] * alon[19:0];
			rsq_q     <= rad_c * rad_c;
		end
		if (cmd.fin) begin
			speed_out_q <= speed_q;
			power_out_q <= power_q;
			index_q     <= 6'(cur_q);
			if (done_q) begin
				steer_q       <= center_q;
				bearing_out_q <= '0;
				inside_out_q  <= 1'b0;
				adv_q         <= 1'b0;
				done_out_q    <= 1'b1;
			end else begin
				bearing_out_q <= bearing_q;
				inside_out_q  <= inside_c;
				adv_q         <= inside_c && match_c;
				done_out_q    <= inside_c && match_c && (cur_next >= len_q);
				if (inside_c && match_c) begin
					steer_q <= center_q;
				end else if (inside_c && (rd_turn_q > 0)) begin
					steer_q <= min_q;
				end else if (inside_c) begin
					steer_q <= max_q;
				end else begin
					steer_q <= 15'(steer_cl);
				end
			end
		end
	end

	assign steer          = steer_q;
	assign speed_cmd      = speed_out_q;
	assign power_cmd      = power_out_q;
	assign target_bearing = bearing_out_q;
	assign active_index   = index_q;
	assign in_radius      = inside_out_q;
	assign advanced       = adv_q;
	assign route_done     = done_out_q;

endmodule

@@ src/waypoint_steering_controller_top.sv @@
// A waypoint load writes the route memory and gives no result. A fix runs from accept to
// result through the cosine and bearing CORDIC passes; a fix past the route end skips them.
// One fix is in flight at a time, so the input stalls until the last fix has finished;
// the next beat is accepted while the result waits.
// Reset (arst_n low) clears route length, active waypoint and configuration to defaults;
// the route memory holds no reset value and must be loaded before use.
module waypoint_steering_controller_top #(
	parameter int ROUTE_DEPTH  = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [5:0]         slot,
	input  logic signed [30:0] lat,
	input  logic signed [31:0] lon,
	input  logic [15:0]        heading,
	input  logic signed [16:0] turn_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        steer,
	output logic [7:0]         speed_cmd,
	output logic               power_cmd,
	output logic [15:0]        target_bearing,
	output logic [5:0]         active_index,
	output logic               in_radius,
	output logic               advanced,
	output logic               route_done,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [14:0]        cfg_data
);
	import wsc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	wsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	wsc_dp #(
		.ROUTE_DEPTH  (ROUTE_DEPTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.slot           (slot),
		.lat            (lat),
		.lon            (lon),
		.heading        (heading),
		.turn_heading   (turn_heading),
		.steer          (steer),
		.speed_cmd      (speed_cmd),
		.power_cmd      (power_cmd),
		.target_bearing (target_bearing),
		.active_index   (active_index),
		.in_radius      (in_radius),
		.advanced       (advanced),
		.route_done     (route_done)
	);

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !op) |=> !$rose(out_valid))
		else $error("waypoint load produced a result beat");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat appeared without a fix in progress");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && route_done && !advanced) |-> (target_bearing == 16'd0 && !in_radius))
		else $error("finished route result carries navigation fields");

endmodule
